// File: rtl/core/bsid_pkg.sv
// ----------------------------------------------------------------------------
// bsid_pkg
// Types and constants shared by the byte stream instruction decoder.
// ----------------------------------------------------------------------------
package bsid_pkg;

  localparam logic [15:0] ENTRY_RESET = 16'h2000;

  // operation classes
  localparam logic [5:0] MN_BRK  = 6'd0;
  localparam logic [5:0] MN_MUL  = 6'd1;
  localparam logic [5:0] MN_DIV  = 6'd2;
  localparam logic [5:0] MN_RET  = 6'd3;
  localparam logic [5:0] MN_SYS  = 6'd4;
  localparam logic [5:0] MN_SPC  = 6'd5;
  localparam logic [5:0] MN_NOP  = 6'd6;
  localparam logic [5:0] MN_MOV  = 6'd7;
  localparam logic [5:0] MN_NOPC = 6'd8;
  localparam logic [5:0] MN_ILL  = 6'd9;
  localparam logic [5:0] MN_LLS  = 6'd10;
  localparam logic [5:0] MN_RLS  = 6'd11;
  localparam logic [5:0] MN_ADD  = 6'd12;
  localparam logic [5:0] MN_LDB  = 6'd13;
  localparam logic [5:0] MN_LD   = 6'd14;
  localparam logic [5:0] MN_STB  = 6'd15;
  localparam logic [5:0] MN_ST   = 6'd16;
  localparam logic [5:0] MN_CMP  = 6'd17;
  localparam logic [5:0] MN_PUSH = 6'd18;
  localparam logic [5:0] MN_POP  = 6'd19;
  localparam logic [5:0] MN_JUMP = 6'd20;
  localparam logic [5:0] MN_CALL = 6'd21;
  localparam logic [5:0] MN_INC  = 6'd30;
  localparam logic [5:0] MN_DEC  = 6'd31;
  localparam logic [5:0] MN_AND  = 6'd32;
  localparam logic [5:0] MN_OR   = 6'd33;
  localparam logic [5:0] MN_XOR  = 6'd34;
  localparam logic [5:0] MN_SWAP = 6'd35;

  // operand forms
  localparam logic [2:0] F_NONE    = 3'd0;
  localparam logic [2:0] F_IMM16   = 3'd1;
  localparam logic [2:0] F_IMM8    = 3'd2;
  localparam logic [2:0] F_REGPAIR = 3'd3;
  localparam logic [2:0] F_MEMREG  = 3'd4;
  localparam logic [2:0] F_MEMIMM  = 3'd5;

  // operand registers
  localparam logic [2:0] OPND_R0   = 3'd0;
  localparam logic [2:0] OPND_R1   = 3'd1;
  localparam logic [2:0] OPND_SP   = 3'd4;
  localparam logic [2:0] OPND_PC   = 3'd5;
  localparam logic [2:0] OPND_NONE = 3'd6;

  localparam logic [1:0] LEN_1 = 2'd1;
  localparam logic [1:0] LEN_2 = 2'd2;
  localparam logic [1:0] LEN_3 = 2'd3;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_req;
  } bsid_in_t;

  typedef struct packed {
    logic [15:0] instr_address;
    logic [7:0]  opcode_value;
    logic [5:0]  mnemonic;
    logic [2:0]  operand_form;
    logic [2:0]  first_operand;
    logic [2:0]  second_operand;
    logic [15:0] immediate;
    logic [1:0]  length;
    logic        is_illegal;
  } bsid_out_t;

  typedef struct packed {
    logic [5:0] mn;
    logic [2:0] form;
    logic [2:0] opa;
    logic [2:0] opb;
    logic [1:0] len;
    logic       ill;
  } bsid_dec_t;

endpackage

// File: rtl/core/byte_stream_instruction_decoder.sv
// ----------------------------------------------------------------------------
// byte_stream_instruction_decoder
// Decodes an 8-bit instruction stream fed one byte per transaction.
// ----------------------------------------------------------------------------
// Takes one code byte per clock cycle when the result side keeps up. Each
// accepted byte passes through an input register, then the opcode table and
// program counter update, and the decoded record of an instruction lands in
// the result register. Opcode and immediate bytes that do not complete an
// instruction give no record. start_req reloads the program counter from the
// entry register (cfg_data, reset 0x2000) and drops a half-collected
// instruction.
// ----------------------------------------------------------------------------
module byte_stream_instruction_decoder
  import bsid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  bsid_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output bsid_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        in_valid_r;
  bsid_in_t    in_data_r;
  logic        out_valid_r;
  bsid_out_t   out_data_r;
  logic [15:0] entry_r;
  logic        adv;
  logic        res_valid;
  bsid_out_t   res;

  assign cfg_ready = 1'b1;
  assign adv       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= ENTRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  bsid_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (adv),
    .item       (in_data_r),
    .entry_addr (entry_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data_r <= res;
    end
  end

  // a held input byte stays put until the step logic takes it
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_data_r))
    else $error("input register lost a byte under stall");

  a_len_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.length == LEN_3) ==
                   (out_data.operand_form == F_IMM16 ||
                    out_data.operand_form == F_MEMIMM)))
    else $error("record length disagrees with operand form");

  a_illegal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_illegal |->
      out_data.mnemonic == MN_ILL && out_data.length == LEN_1 &&
      out_data.operand_form == F_NONE && out_data.immediate == 16'd0)
    else $error("illegal record is malformed");

endmodule

// File: rtl/core/bsid_decode.sv
// ----------------------------------------------------------------------------
// bsid_decode
// Opcode table: maps one opcode byte to class, form, operands and length.
// ----------------------------------------------------------------------------
module bsid_decode
  import bsid_pkg::*;
(
  input  logic [7:0] opcode,
  output bsid_dec_t  dec
);

  logic [1:0] rr;
  logic [1:0] rm;
  logic [2:0] rr_o;
  logic [2:0] rm_o;
  logic [7:0] d98;
  logic [7:0] da2;
  logic [7:0] dc5;
  logic [7:0] dc9;
  logic [7:0] dcd;
  logic [7:0] dd9;
  logic [5:0] mn;
  logic [2:0] form;
  logic [2:0] opa;
  logic [2:0] opb;

  assign rr   = opcode[3:2];
  assign rm   = opcode[1:0];
  assign rr_o = {1'b0, rr};
  assign rm_o = {1'b0, rm};
  assign d98  = opcode - 8'h98;
  assign da2  = opcode - 8'ha2;
  assign dc5  = opcode - 8'hc5;
  assign dc9  = opcode - 8'hc9;
  assign dcd  = opcode - 8'hcd;
  assign dd9  = opcode - 8'hd9;

  always_comb begin
    mn   = MN_ILL;
    form = F_NONE;
    opa  = OPND_NONE;
    opb  = OPND_NONE;
    if (opcode < 8'h10) begin
      case (opcode[3:0])
        4'h0: mn = MN_BRK;
        4'h1: begin mn = MN_MUL; form = F_IMM16; opa = OPND_R0; end
        4'h2: begin mn = MN_MUL; form = F_REGPAIR; opa = OPND_R0; opb = OPND_R1; end
        4'h3: begin mn = MN_DIV; form = F_IMM16; opa = OPND_R0; end
        4'h4: begin mn = MN_DIV; form = F_REGPAIR; opa = OPND_R0; opb = OPND_R1; end
        4'h5: mn = MN_RET;
        4'h6: begin mn = MN_SYS; form = F_IMM8; end
        4'h7: mn = MN_SPC;
        4'h8: mn = MN_NOP;
        4'h9: begin mn = MN_MOV; form = F_IMM16; opa = OPND_SP; end
        4'ha: begin mn = MN_MOV; form = F_REGPAIR; opa = OPND_R0; opb = OPND_SP; end
        4'hb: begin mn = MN_DIV; form = F_REGPAIR; opa = OPND_R1; opb = OPND_SP; end
        4'hc: mn = MN_NOPC;
        4'he: begin mn = MN_LLS; opa = OPND_R0; end
        4'hf: begin mn = MN_RLS; opa = OPND_R0; end
        default: mn = MN_ILL;
      endcase
    end else if (opcode < 8'h14) begin
      mn = MN_MOV; form = F_IMM16; opa = rm_o;
    end else if (opcode < 8'h20) begin
      mn = MN_ILL;
    end else if (opcode < 8'h90) begin
      // stores take the memory register first
      case (opcode[7:4])
        4'h2: begin mn = MN_MOV; form = F_REGPAIR; opa = rr_o; opb = rm_o; end
        4'h3: begin mn = MN_ADD; form = F_REGPAIR; opa = rr_o; opb = rm_o; end
        4'h4: begin mn = MN_LDB; form = F_MEMREG; opa = rr_o; opb = rm_o; end
        4'h5: begin mn = MN_LD;  form = F_MEMREG; opa = rr_o; opb = rm_o; end
        4'h6: begin mn = MN_STB; form = F_MEMREG; opa = rm_o; opb = rr_o; end
        4'h7: begin mn = MN_ST;  form = F_MEMREG; opa = rm_o; opb = rr_o; end
        default: begin mn = MN_CMP; form = F_REGPAIR; opa = rr_o; opb = rm_o; end
      endcase
    end else if (opcode < 8'h98) begin
      mn = (opcode < 8'h94) ? MN_PUSH : MN_POP; opa = rm_o;
    end else if (opcode < 8'ha2) begin
      mn = MN_JUMP + d98[5:0]; form = F_IMM16;
    end else if (opcode < 8'ha6) begin
      mn = MN_CMP; form = F_IMM16; opa = da2[2:0];
    end else if (opcode == 8'ha6) begin
      mn = MN_PUSH; opa = OPND_SP;
    end else if (opcode == 8'ha7) begin
      mn = MN_PUSH; opa = OPND_PC;
    end else if (opcode < 8'hb0) begin
      mn = (opcode < 8'hac) ? MN_INC : MN_DEC; opa = rm_o;
    end else if (opcode < 8'hc0) begin
      mn = MN_LDB + {4'b0, rr}; form = F_MEMIMM; opa = rm_o;
    end else if (opcode < 8'hc5) begin
      mn = MN_ILL;
    end else if (opcode < 8'hc9) begin
      mn = MN_JUMP; opa = dc5[2:0];
    end else if (opcode < 8'hcd) begin
      mn = MN_CALL; opa = dc9[2:0];
    end else if (opcode < 8'hd0) begin
      mn = MN_AND + dcd[5:0]; form = F_IMM16; opa = OPND_R0;
    end else if (opcode < 8'hd8) begin
      mn   = (opcode < 8'hd4) ? MN_AND : MN_OR;
      form = F_REGPAIR;
      opa  = OPND_R0;
      opb  = (rm == 2'd0) ? OPND_R1 : rm_o;
    end else if (opcode == 8'hd8) begin
      mn = MN_XOR; form = F_REGPAIR; opa = OPND_R0; opb = OPND_R1;
    end else if (opcode == 8'hd9) begin
      mn = MN_ILL;
    end else if (opcode < 8'hdd) begin
      mn = MN_XOR; form = F_REGPAIR; opa = OPND_R0; opb = dd9[2:0];
    end else if (opcode < 8'he0) begin
      mn = MN_SWAP; opa = OPND_R0;
    end else if (opcode < 8'he4) begin
      mn = MN_ADD; form = F_IMM16; opa = rm_o;
    end
  end

  always_comb begin
    dec.mn   = mn;
    dec.form = form;
    dec.opa  = opa;
    dec.opb  = opb;
    dec.ill  = (mn == MN_ILL);
    if (form == F_IMM16 || form == F_MEMIMM) begin
      dec.len = LEN_3;
    end else if (form == F_IMM8) begin
      dec.len = LEN_2;
    end else begin
      dec.len = LEN_1;
    end
  end

endmodule

// File: rtl/core/bsid_step.sv
// ----------------------------------------------------------------------------
// bsid_step
// Program counter and pending-instruction state; builds the decoded record
// on the last byte of each instruction.
// ----------------------------------------------------------------------------
module bsid_step
  import bsid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  bsid_in_t    item,
  input  logic [15:0] entry_addr,
  output logic        res_valid,
  output bsid_out_t   res
);

  logic [15:0] pc_r, pc_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  imm_lo_r, imm_lo_nxt;
  logic [15:0] opaddr_r, opaddr_nxt;

  logic [15:0] pc_eff;
  logic [1:0]  need_eff;
  logic [7:0]  op_sel;
  bsid_dec_t   dec;

  // start drops any pending instruction before this byte
  assign pc_eff   = item.start_req ? entry_addr : pc_r;
  assign need_eff = item.start_req ? 2'd0 : need_r;
  assign op_sel   = (need_eff == 2'd0) ? item.code_byte : pend_r;

  bsid_decode u_decode (
    .opcode (op_sel),
    .dec    (dec)
  );

  always_comb begin
    pc_nxt     = pc_eff + 16'd1;
    need_nxt   = need_eff;
    pend_nxt   = pend_r;
    imm_lo_nxt = imm_lo_r;
    opaddr_nxt = opaddr_r;
    res_valid  = 1'b0;

    res.instr_address  = opaddr_r;
    res.opcode_value   = op_sel;
    res.mnemonic       = dec.mn;
    res.operand_form   = dec.form;
    res.first_operand  = dec.opa;
    res.second_operand = dec.opb;
    res.immediate      = 16'd0;
    res.length         = dec.len;
    res.is_illegal     = dec.ill;

    if (need_eff == 2'd0) begin
      opaddr_nxt        = pc_eff;
      res.instr_address = pc_eff;
      if (dec.len == LEN_1) begin
        res_valid = 1'b1;
      end else begin
        pend_nxt = item.code_byte;
        need_nxt = dec.len - 2'd1;
      end
    end else if (need_eff == 2'd2) begin
      imm_lo_nxt = item.code_byte;
      need_nxt   = 2'd1;
    end else begin
      need_nxt  = 2'd0;
      res_valid = 1'b1;
      if (dec.len == LEN_3) begin
        res.immediate = {item.code_byte, imm_lo_r};
      end else begin
        res.immediate = {8'd0, item.code_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= ENTRY_RESET;
      need_r <= 2'd0;
    end else if (advance) begin
      pc_r   <= pc_nxt;
      need_r <= need_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pend_r   <= pend_nxt;
      imm_lo_r <= imm_lo_nxt;
      opaddr_r <= opaddr_nxt;
    end
  end

endmodule
